### src/dllt_pkg.sv
`timescale 1ns / 1ps

package dllt_pkg;

    localparam int KEYS       = 1024;
    localparam int KEY_W      = 10;
    localparam int TABLE_SIZE = KEYS + 2;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    localparam logic [IDX_W-1:0] KEYS_IDX = IDX_W'(KEYS);
    localparam logic [IDX_W-1:0] HEAD_IDX = IDX_W'(KEYS);
    localparam logic [IDX_W-1:0] TAIL_IDX = IDX_W'(KEYS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_WALK   = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] new_key;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0] value;
        logic             value_valid;
        logic             at_end;
    } out_t;

    typedef struct packed {
        logic clear;
        logic rd;
        logic exec;
        logic wr2;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic needs_wr2;
        logic out_free;
    } dp_status_t;

endpackage

### src/doubly_linked_list_table.sv
`timescale 1ns / 1ps
// Ordered list of distinct 10-bit keys kept as a doubly linked list in two link
// tables indexed by the key, with head and tail sentinel entries past the keys.
// The input channel (s_valid, s_ready, s_data) carries a mode, a key and a new key:
// append at the tail, insert the new key after the key, unlink the key, or step
// the walk cursor. Every input transfer gives exactly one result transfer on
// (m_valid, m_ready, m_data); only a walk returns a key, or the end flag.
// The result is loaded into the output register in the EXEC state for walk, unlink
// and out-of-range items, and in the WR2 state for append and insert, which need a
// second write on the single write port of each link table. The state that loads
// the result waits until the output register is free. One item is in work at a time.
// After reset the block sweeps all 1026 entries of both link tables, one entry per
// cycle; s_ready stays low during the sweep. A finished result waits in the
// output register while the next item is accepted; if the receiver still holds
// m_ready low when that item finishes, the block holds it until the register is free.
module doubly_linked_list_table (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dllt_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dllt_pkg::out_t  m_data
);
    import dllt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dllt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dllt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### src/dllt_ctrl.sv
`timescale 1ns / 1ps

module dllt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dllt_pkg::dp_status_t  status,
    output dllt_pkg::ctrl_cmd_t   cmd
);
    import dllt_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_WR2   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.needs_wr2) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_WR2;
                end else if (status.out_free) begin
                    cmd.exec     = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WR2: begin
                if (status.out_free) begin
                    cmd.wr2      = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### src/dllt_datapath.sv
`timescale 1ns / 1ps

module dllt_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dllt_pkg::ctrl_cmd_t   cmd,
    output dllt_pkg::dp_status_t  status,
    input  dllt_pkg::in_t         s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dllt_pkg::out_t        m_data
);
    import dllt_pkg::*;

    logic [IDX_W-1:0] next_mem [TABLE_SIZE];
    logic [IDX_W-1:0] prev_mem [TABLE_SIZE];

    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] last_key_reg;
    logic [IDX_W-1:0] cursor_reg;
    logic [IDX_W-1:0] nx_rd_reg;
    logic [IDX_W-1:0] pv_rd_reg;
    in_t              item_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic             nx_we;
    logic [IDX_W-1:0] nx_wa;
    logic [IDX_W-1:0] nx_wd;
    logic             pv_we;
    logic [IDX_W-1:0] pv_wa;
    logic [IDX_W-1:0] pv_wd;
    logic [IDX_W-1:0] nx_ra;
    logic [IDX_W-1:0] pv_ra;
    logic [IDX_W-1:0] k_idx;
    logic [IDX_W-1:0] nk_idx;
    logic             key_ok;
    logic             nk_ok;
    out_t             result;

    assign k_idx  = IDX_W'(item_reg.key);
    assign nk_idx = IDX_W'(item_reg.new_key);
    assign key_ok = k_idx < KEYS_IDX;
    assign nk_ok  = nk_idx < KEYS_IDX;

    assign nx_ra = (s_data.mode == MODE_WALK) ? cursor_reg : IDX_W'(s_data.key);
    assign pv_ra = IDX_W'(s_data.key);

    assign status.clear_last = (clr_cnt_reg == LAST_IDX);
    assign status.needs_wr2  = key_ok && ((item_reg.mode == MODE_APPEND) ||
                                          ((item_reg.mode == MODE_INSERT) && nk_ok));
    assign status.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        nx_we = 1'b0;
        nx_wa = '0;
        nx_wd = '0;
        pv_we = 1'b0;
        pv_wa = '0;
        pv_wd = '0;
        if (cmd.clear) begin
            nx_we = 1'b1;
            nx_wa = clr_cnt_reg;
            nx_wd = (clr_cnt_reg == HEAD_IDX) ? TAIL_IDX : clr_cnt_reg;
            pv_we = 1'b1;
            pv_wa = clr_cnt_reg;
            pv_wd = (clr_cnt_reg == TAIL_IDX) ? HEAD_IDX : clr_cnt_reg;
        end else if (cmd.exec && key_ok) begin
            unique case (item_reg.mode)
                MODE_APPEND: begin
                    nx_we = 1'b1;
                    nx_wa = k_idx;
                    nx_wd = TAIL_IDX;
                    pv_we = 1'b1;
                    pv_wa = k_idx;
                    pv_wd = last_key_reg;
                end
                MODE_INSERT: begin
                    nx_we = nk_ok;
                    nx_wa = nk_idx;
                    nx_wd = nx_rd_reg;
                    pv_we = nk_ok;
                    pv_wa = nk_idx;
                    pv_wd = k_idx;
                end
                MODE_DELETE: begin
                    pv_we = 1'b1;
                    pv_wa = nx_rd_reg;
                    pv_wd = pv_rd_reg;
                    nx_we = 1'b1;
                    nx_wa = pv_rd_reg;
                    nx_wd = nx_rd_reg;
                end
                MODE_WALK: begin
                    nx_we = 1'b0;
                end
                default: begin
                    nx_we = 1'b0;
                end
            endcase
        end else if (cmd.wr2) begin
            if (item_reg.mode == MODE_APPEND) begin
                nx_we = 1'b1;
                nx_wa = last_key_reg;
                nx_wd = k_idx;
                pv_we = 1'b1;
                pv_wa = TAIL_IDX;
                pv_wd = k_idx;
            end else begin
                nx_we = 1'b1;
                nx_wa = k_idx;
                nx_wd = nk_idx;
                pv_we = 1'b1;
                pv_wa = nx_rd_reg;
                pv_wd = nk_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.rd) begin
            nx_rd_reg <= next_mem[nx_ra];
            pv_rd_reg <= prev_mem[pv_ra];
            item_reg  <= s_data;
        end
    end

    always_comb begin
        result = '0;
        if (item_reg.mode == MODE_WALK) begin
            if (nx_rd_reg >= HEAD_IDX) begin
                result.at_end = 1'b1;
            end else begin
                result.value       = nx_rd_reg[KEY_W-1:0];
                result.value_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            last_key_reg <= HEAD_IDX;
            cursor_reg   <= HEAD_IDX;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (pv_we && (pv_wa == TAIL_IDX)) begin
                last_key_reg <= pv_wd;
            end
            if (cmd.out_load && (item_reg.mode == MODE_WALK)) begin
                cursor_reg <= (nx_rd_reg >= HEAD_IDX) ? HEAD_IDX : nx_rd_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sim/doubly_linked_list_table_tb.sv
`timescale 1ns / 1ps

module doubly_linked_list_table_tb;

    import dllt_pkg::*;

    localparam int ITEMS_PER_PHASE = 375;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 5000;
    localparam int MAX_REPORTS     = 40;

    class link_list_scoreboard;
        logic [IDX_W-1:0] fwd_link [TABLE_SIZE];
        logic [IDX_W-1:0] back_link [TABLE_SIZE];
        logic [IDX_W-1:0] tail_key;
        logic [IDX_W-1:0] cursor;
        out_t             due_results [$];
        bit               on_list [KEYS];
        logic [KEY_W-1:0] list_order [$];
        int               mode_count [4];
        int               walk_keys;
        int               walk_ends;
        int               checked;
        int               errors;

        function new();
            foreach (fwd_link[i]) begin
                fwd_link[i]  = IDX_W'(i);
                back_link[i] = IDX_W'(i);
            end
            fwd_link[HEAD_IDX]  = TAIL_IDX;
            back_link[TAIL_IDX] = HEAD_IDX;
            tail_key = HEAD_IDX;
            cursor   = HEAD_IDX;
            foreach (mode_count[i]) mode_count[i] = 0;
            walk_keys = 0;
            walk_ends = 0;
            checked   = 0;
            errors    = 0;
        endfunction

        function out_t step_list(in_t op);
            logic [IDX_W-1:0] k;
            logic [IDX_W-1:0] nk;
            logic [IDX_W-1:0] at;
            logic [IDX_W-1:0] nbr;
            logic [IDX_W-1:0] pred;
            out_t             res;
            res = '0;
            k   = IDX_W'(op.key);
            nk  = IDX_W'(op.new_key);
            if (op.mode == MODE_WALK) begin
                at = cursor;
                if (at > LAST_IDX) at = HEAD_IDX;
                at = fwd_link[at];
                if (at >= HEAD_IDX) begin
                    res.at_end = 1'b1;
                    cursor = HEAD_IDX;
                end else begin
                    res.value       = at[KEY_W-1:0];
                    res.value_valid = 1'b1;
                    cursor = at;
                end
            end else if (k < KEYS_IDX) begin
                case (op.mode)
                    MODE_APPEND: begin
                        at = tail_key;
                        if (at > LAST_IDX) at = HEAD_IDX;
                        fwd_link[k]         = TAIL_IDX;
                        back_link[k]        = at;
                        fwd_link[at]        = k;
                        back_link[TAIL_IDX] = k;
                    end
                    MODE_INSERT: begin
                        if (nk < KEYS_IDX) begin
                            nbr = fwd_link[k];
                            fwd_link[nk]   = nbr;
                            back_link[nk]  = k;
                            fwd_link[k]    = nk;
                            back_link[nbr] = nk;
                        end
                    end
                    default: begin
                        pred = back_link[k];
                        nbr  = fwd_link[k];
                        back_link[nbr] = pred;
                        fwd_link[pred] = nbr;
                    end
                endcase
                tail_key = back_link[TAIL_IDX];
            end
            return res;
        endfunction

        function void note_op(in_t op);
            out_t res;
            res = step_list(op);
            mode_count[op.mode]++;
            if (res.value_valid) walk_keys++;
            if (res.at_end) walk_ends++;
            due_results = {due_results, res};
        endfunction

        function void check_result(out_t got);
            out_t want;
            checked++;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result transfer: expected none, actual %h",
                             $time, got);
            end else begin
                want = due_results.pop_front();
                if (got.value !== want.value) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: value mismatch: expected %0d, actual %0d",
                                 $time, want.value, got.value);
                end
                if (got.value_valid !== want.value_valid) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: value_valid mismatch: expected %0b, actual %0b",
                                 $time, want.value_valid, got.value_valid);
                end
                if (got.at_end !== want.at_end) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: at_end mismatch: expected %0b, actual %0b",
                                 $time, want.at_end, got.at_end);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void collect_list();
            logic [IDX_W-1:0] at;
            list_order.delete();
            foreach (on_list[i]) on_list[i] = 1'b0;
            at = fwd_link[HEAD_IDX];
            while (at < KEYS_IDX && !on_list[at[KEY_W-1:0]]) begin
                on_list[at[KEY_W-1:0]] = 1'b1;
                list_order = {list_order, at[KEY_W-1:0]};
                at = fwd_link[at];
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;

    link_list_scoreboard sb;
    int               send_idle_pct;
    int               stall_pct;
    int               hold_left;
    int               quiet_cycles;
    logic [KEY_W-1:0] dropped_key;

    doubly_linked_list_table u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_op(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                         QUIET_LIMIT, sb.pending());
                $display("doubly_linked_list_table_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic in_t op_of(logic [1:0] mode, int key, int new_key);
        in_t op;
        op.mode    = mode;
        op.key     = KEY_W'(key);
        op.new_key = KEY_W'(new_key);
        return op;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do begin
            k = KEY_W'($urandom_range(0, KEYS - 1));
        end while (sb.on_list[k]);
        return k;
    endfunction

    // Mostly well-formed list operations on the keys currently reachable from
    // the head, with a little noise: random modes and repeated unlinks.
    function automatic in_t next_random_op();
        in_t op;
        int  roll;
        int  count;
        op.mode    = MODE_WALK;
        op.key     = KEY_W'($urandom_range(0, KEYS - 1));
        op.new_key = KEY_W'($urandom_range(0, KEYS - 1));
        roll = $urandom_range(0, 99);
        sb.collect_list();
        count = sb.list_order.size();
        if (roll < 4) begin
            op.mode = 2'($urandom_range(MODE_APPEND, MODE_DELETE));
        end else if (roll < 8) begin
            op.mode = MODE_DELETE;
            op.key  = dropped_key;
        end else if (roll < 40) begin
            op.mode = MODE_WALK;
        end else if (count == 0 || (count < 16 && roll < 60)) begin
            op.mode = MODE_APPEND;
            op.key  = fresh_key();
        end else if (count < 16 && roll < 80) begin
            op.mode    = MODE_INSERT;
            op.key     = sb.list_order[$urandom_range(0, count - 1)];
            op.new_key = fresh_key();
        end else begin
            op.mode     = MODE_DELETE;
            op.key      = sb.list_order[$urandom_range(0, count - 1)];
            dropped_key = op.key;
        end
        return op;
    endfunction

    task automatic offer_op(input in_t op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() > 0) @(negedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        dropped_key   = '0;
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        offer_op(op_of(MODE_WALK,   1023, 1023));
        offer_op(op_of(MODE_APPEND, 0,    1023));
        offer_op(op_of(MODE_APPEND, 1023, 0));
        offer_op(op_of(MODE_INSERT, 0,    512));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_DELETE, 512,  0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_DELETE, 5,    0));
        offer_op(op_of(MODE_INSERT, 7,    8));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_INSERT, 20,   0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_APPEND, 0,    0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_APPEND, 1023, 0));
        offer_op(op_of(MODE_DELETE, 0,    0));
        offer_op(op_of(MODE_DELETE, 1023, 0));
        offer_op(op_of(MODE_WALK,   0,    0));
        offer_op(op_of(MODE_APPEND, 341,  682));
        offer_op(op_of(MODE_DELETE, 341,  682));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_left     = HOLD_CYCLES;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default: begin
                    send_idle_pct = 29;
                    stall_pct     = 29;
                end
            endcase
            repeat (ITEMS_PER_PHASE) offer_op(next_random_op());
            drain();
        end

        repeat (20) @(negedge aclk);
        $display("Covered %0d appends, %0d inserts, %0d unlinks and %0d walk steps.",
                 sb.mode_count[MODE_APPEND], sb.mode_count[MODE_INSERT],
                 sb.mode_count[MODE_DELETE], sb.mode_count[MODE_WALK]);
        $display("Walks returned %0d keys and ended %0d times; %0d results checked.",
                 sb.walk_keys, sb.walk_ends, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("doubly_linked_list_table_tb: done, clean");
        end else begin
            $display("doubly_linked_list_table_tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
src/dllt_pkg.sv
src/dllt_ctrl.sv
src/dllt_datapath.sv
src/doubly_linked_list_table.sv
sim/doubly_linked_list_table_tb.sv
